// File: src/dnle_pkg.sv
// ----------------------------------------------------------------------------
// DNS name label encoder package
// Shared widths, character codes, state and command types for the encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package dnle_pkg;

  // Width of one name character and of one wire byte.
  localparam int unsigned CHAR_W = 8;
  // Width of the label length register; holds the largest allowed label size.
  localparam int unsigned LEN_W = 6;
  // Default label buffer capacity.
  localparam int unsigned MAX_LABEL_DEF = 32;

  localparam logic [CHAR_W-1:0] DOT_CODE = 8'd46;
  localparam logic [CHAR_W-1:0] END_CODE = 8'd0;

  // Controller states, one-hot.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LEN  = 4'b0010,
    ST_DATA = 4'b0100,
    ST_TERM = 4'b1000
  } state_e;

  // Which source feeds the output register.
  typedef enum logic [1:0] {
    SEL_LEN  = 2'd0,
    SEL_DATA = 2'd1,
    SEL_TERM = 2'd2
  } out_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     buf_wr;      // store the input character at the label tail
    logic     ovf_set;     // mark the label as truncated
    logic     rd_rst;      // rewind the read index to the first entry
    logic     rd_adv;      // step the read index
    logic     out_load;    // load a result into the output register
    out_sel_e out_sel;
    logic     out_last;
    logic     label_clr;   // label done: clear length and overflow
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_dot;
    logic is_end;
    logic len_full;
    logic len_zero;
    logic idx_last;
    logic out_free;
  } status_t;

endpackage : dnle_pkg

`default_nettype wire

// File: src/dnle_datapath.sv
// ----------------------------------------------------------------------------
// DNS name label encoder datapath
// Label buffer memory, length and overflow registers, read index and the
// output register.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_datapath #(
  parameter int unsigned MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire  [dnle_pkg::CHAR_W-1:0]   char_code_i,
  input  wire                           out_ready_i,
  input  dnle_pkg::cmd_t                cmd_i,
  output dnle_pkg::status_t             status_o,
  output logic                          out_valid_o,
  output logic [dnle_pkg::CHAR_W-1:0]   out_byte_o,
  output logic                          run_last_o,
  output logic                          name_end_o,
  output logic                          label_overflow_o
);

  localparam int unsigned CHAR_W = dnle_pkg::CHAR_W;
  localparam int unsigned LEN_W  = dnle_pkg::LEN_W;
  localparam int unsigned IDX_W  = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;

  logic [CHAR_W-1:0] label_mem [MAX_LABEL];

  logic [LEN_W-1:0]  len_q, len_d;
  logic              ovf_q, ovf_d;
  logic [IDX_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CHAR_W-1:0] rd_data_q;

  logic              out_valid_q, out_valid_d;
  logic [CHAR_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q;
  logic              out_end_q, out_end_d;
  logic              out_ovf_q;
  logic              out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    status_o          = '0;
    status_o.is_dot   = (char_code_i == dnle_pkg::DOT_CODE);
    status_o.is_end   = (char_code_i == dnle_pkg::END_CODE);
    status_o.len_full = (len_q == LEN_W'(MAX_LABEL));
    status_o.len_zero = (len_q == '0);
    status_o.idx_last = (({{(LEN_W-IDX_W){1'b0}}, rd_idx_q} + LEN_W'(1)) == len_q);
    status_o.out_free = out_free;
  end

  // Length and overflow bookkeeping.
  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    if (cmd_i.label_clr) begin
      len_d = '0;
      ovf_d = 1'b0;
    end else begin
      if (cmd_i.buf_wr) begin
        len_d = len_q + LEN_W'(1);
      end
      if (cmd_i.ovf_set) begin
        ovf_d = 1'b1;
      end
    end
  end

  always_comb begin
    rd_idx_d = rd_idx_q;
    if (cmd_i.rd_rst) begin
      rd_idx_d = '0;
    end else if (cmd_i.rd_adv) begin
      rd_idx_d = (rd_idx_q == IDX_W'(MAX_LABEL - 1)) ? '0 : rd_idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q    <= '0;
      ovf_q    <= 1'b0;
      rd_idx_q <= '0;
    end else begin
      len_q    <= len_d;
      ovf_q    <= ovf_d;
      rd_idx_q <= rd_idx_d;
    end
  end

  // Label buffer: one write port at the label tail, one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.buf_wr) begin
      label_mem[len_q[IDX_W-1:0]] <= char_code_i;
    end
    rd_data_q <= label_mem[rd_idx_d];
  end

  // Output register.
  always_comb begin
    out_byte_d = '0;
    out_end_d  = 1'b0;
    unique case (cmd_i.out_sel)
      dnle_pkg::SEL_LEN:  out_byte_d = {{(CHAR_W-LEN_W){1'b0}}, len_q};
      dnle_pkg::SEL_DATA: out_byte_d = rd_data_q;
      dnle_pkg::SEL_TERM: begin
        out_byte_d = '0;
        out_end_d  = 1'b1;
      end
      default: begin
        out_byte_d = '0;
        out_end_d  = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_byte_q <= out_byte_d;
      out_last_q <= cmd_i.out_last;
      out_end_q  <= out_end_d;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_byte_o       = out_byte_q;
  assign run_last_o       = out_last_q;
  assign name_end_o       = out_end_q;
  assign label_overflow_o = out_ovf_q;

endmodule : dnle_datapath

`default_nettype wire

// File: src/dnle_ctrl.sv
// ----------------------------------------------------------------------------
// DNS name label encoder controller
// Sequences buffering of characters and the replay of a finished label.
// ----------------------------------------------------------------------------
`default_nettype none

module dnle_ctrl (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  dnle_pkg::status_t  status_i,
  output dnle_pkg::cmd_t     cmd_o
);

  dnle_pkg::state_e state_q, state_d;
  logic             closing_q, closing_d;
  logic             in_acc;

  assign in_ready_o = (state_q == dnle_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  always_comb begin
    state_d   = state_q;
    closing_d = closing_q;
    cmd_o     = '0;
    cmd_o.out_sel = dnle_pkg::SEL_LEN;
    unique case (state_q)
      dnle_pkg::ST_IDLE: begin
        cmd_o.rd_rst = 1'b1;
        if (in_acc) begin
          if (status_i.is_dot || status_i.is_end) begin
            closing_d = status_i.is_end;
            state_d   = dnle_pkg::ST_LEN;
          end else if (status_i.len_full) begin
            cmd_o.ovf_set = 1'b1;
          end else begin
            cmd_o.buf_wr = 1'b1;
          end
        end
      end
      dnle_pkg::ST_LEN: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = dnle_pkg::SEL_LEN;
          cmd_o.out_last = !closing_q && status_i.len_zero;
          if (!status_i.len_zero) begin
            state_d = dnle_pkg::ST_DATA;
          end else if (closing_q) begin
            state_d = dnle_pkg::ST_TERM;
          end else begin
            cmd_o.label_clr = 1'b1;
            state_d         = dnle_pkg::ST_IDLE;
          end
        end
      end
      dnle_pkg::ST_DATA: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_sel  = dnle_pkg::SEL_DATA;
          cmd_o.out_last = !closing_q && status_i.idx_last;
          cmd_o.rd_adv   = 1'b1;
          if (status_i.idx_last) begin
            if (closing_q) begin
              state_d = dnle_pkg::ST_TERM;
            end else begin
              cmd_o.label_clr = 1'b1;
              state_d         = dnle_pkg::ST_IDLE;
            end
          end
        end
      end
      dnle_pkg::ST_TERM: begin
        if (status_i.out_free) begin
          cmd_o.out_load  = 1'b1;
          cmd_o.out_sel   = dnle_pkg::SEL_TERM;
          cmd_o.out_last  = 1'b1;
          cmd_o.label_clr = 1'b1;
          state_d         = dnle_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dnle_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= dnle_pkg::ST_IDLE;
      closing_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      closing_q <= closing_d;
    end
  end

endmodule : dnle_ctrl

`default_nettype wire

// File: src/dns_name_label_encoder_unit.sv
// ----------------------------------------------------------------------------
// DNS name label encoder unit
// Converts a dotted domain name, one character per transaction, into DNS wire
// form: a length byte before each label and a zero byte at the end.
// ----------------------------------------------------------------------------
// Characters arrive one per input transaction. An ordinary character is
// stored in the label buffer and is accepted without producing output. A
// dot emits the label: its length byte followed by the stored bytes, one
// output transaction per cycle while the output side does not stall. A zero
// character does the same and then emits the terminating zero byte with
// name_end set. An empty label gives a length byte of zero. Characters
// beyond MAX_LABEL are dropped; the length counts only the kept bytes and
// label_overflow is set on every output byte of that label, including the
// terminating zero. run_last marks the final output caused by one input
// character. The label replay reads the buffer through its single
// registered read port, one byte per cycle while the output side does not
// stall, and input is held off while the replay runs. The output register
// lets a waiting result sit while the next character is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_name_label_encoder_unit #(
  parameter int unsigned MAX_LABEL = dnle_pkg::MAX_LABEL_DEF
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           in_valid_i,
  output logic                          in_ready_o,
  input  wire  [dnle_pkg::CHAR_W-1:0]   char_code_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic [dnle_pkg::CHAR_W-1:0]   out_byte_o,
  output logic                          run_last_o,
  output logic                          name_end_o,
  output logic                          label_overflow_o
);

  // Command and status bundles between the controller and the datapath.
  dnle_pkg::cmd_t    cmd;
  dnle_pkg::status_t status;

  // The controller decides when to buffer, when to replay and what to emit.
  dnle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the label buffer, its length, the truncation flag
  // and the output register.
  dnle_datapath #(
    .MAX_LABEL (MAX_LABEL)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .char_code_i      (char_code_i),
    .out_ready_i      (out_ready_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (out_valid_o),
    .out_byte_o       (out_byte_o),
    .run_last_o       (run_last_o),
    .name_end_o       (name_end_o),
    .label_overflow_o (label_overflow_o)
  );

endmodule : dns_name_label_encoder_unit

`default_nettype wire
